>>> rtl/cylinder_tile_vertex_generator_core_defines.svh
// Assertion macros used by the cylinder tile vertex generator checker.
`ifndef CYLINDER_TILE_VERTEX_GENERATOR_CORE_DEFINES_SVH
`define CYLINDER_TILE_VERTEX_GENERATOR_CORE_DEFINES_SVH

// Checks a consequent in the same cycle as its antecedent.
`define CTVG_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ctvg assertion failed");

// Checks a consequent in the cycle after its antecedent.
`define CTVG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ctvg assertion failed");

`endif

>>> rtl/ctvg_pkg.sv
// Types, constants and latencies of the cylinder tile vertex generator.
package ctvg_pkg;

  localparam int FRAC_BITS = 14;
  localparam int VERTS     = 6;

  localparam logic [1:0] OP_SIDE   = 2'd0;
  localparam logic [1:0] OP_TOP    = 2'd1;
  localparam logic [1:0] OP_BOTTOM = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic CFG_STACK_COUNT = 1'b0;
  localparam logic CFG_SLICE_COUNT = 1'b1;

  localparam logic [30:0] Q30_ONE = 31'h4000_0000;
  localparam logic [31:0] PI_Q30  = 32'd3373259426;

  localparam logic [15:0] CAP_HALF = 16'(1 << (FRAC_BITS - 1));
  localparam logic [15:0] CAP_ONE  = 16'(1 << FRAC_BITS);

  localparam int HORNER_STEPS = 7;
  localparam int STEP_LAT     = 3;
  localparam int unsigned SIN_DEN [HORNER_STEPS] = '{156, 110, 72, 42, 20, 6, 0};
  localparam int unsigned COS_DEN [HORNER_STEPS] = '{182, 132, 90, 56, 30, 12, 2};

  localparam int MOD_NW   = 9;
  localparam int MOD_BPS  = 5;
  localparam int MOD_LAT  = (MOD_NW + MOD_BPS - 1) / MOD_BPS;
  localparam int XDIV_NW  = 41;
  localparam int XDIV_BPS = 6;
  localparam int XDIV_LAT = (XDIV_NW + XDIV_BPS - 1) / XDIV_BPS;
  localparam int SDIV_NW  = 23;
  localparam int SDIV_BPS = 6;
  localparam int SDIV_LAT = (SDIV_NW + SDIV_BPS - 1) / SDIV_BPS;

  localparam int ANG_LAT   = MOD_LAT + 2 + XDIV_LAT + 1 + HORNER_STEPS * STEP_LAT + 1;
  localparam int SCALE_LAT = SDIV_LAT + 2;

  localparam logic [1:0] ORDER_FWD [VERTS] = '{2'd0, 2'd2, 2'd3, 2'd0, 2'd3, 2'd1};
  localparam logic [1:0] ORDER_REV [VERTS] = '{2'd0, 2'd3, 2'd2, 2'd0, 2'd1, 2'd3};

  typedef struct packed {
    logic [30:0] smag;
    logic [30:0] cmag;
    logic        sneg;
    logic        cneg;
  } trig_t;

  typedef struct packed {
    logic signed [15:0] nz;
    logic signed [15:0] ny;
    logic signed [15:0] nx;
    logic signed [15:0] pz;
    logic signed [15:0] py;
    logic signed [15:0] px;
  } corner_t;

  typedef struct packed {
    logic              rev;
    corner_t [3:0]     corner;
  } tile_t;

  function automatic logic [15:0] apply_sign(input logic neg, input logic [15:0] mag);
    return neg ? 16'(~mag + 16'd1) : mag;
  endfunction

endpackage

>>> rtl/ctvg_dly.sv
// Enabled delay line that keeps sideband data aligned with the datapath.
module ctvg_dly #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] sr_q [N];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < N; i++) sr_q[i] <= '0;
    end else if (en_i) begin
      sr_q[0] <= d_i;
      for (int i = 1; i < N; i++) sr_q[i] <= sr_q[i-1];
    end
  end

  assign q_o = sr_q[N-1];

endmodule

>>> rtl/ctvg_div.sv
// Pipelined restoring divider producing BPS quotient bits per stage.
module ctvg_div #(
  parameter int NW  = 23,
  parameter int DW  = 9,
  parameter int BPS = 6
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [NW-1:0] quot_o,
  output logic [DW-1:0] rem_o
);

  localparam int NSTG = (NW + BPS - 1) / BPS;

  logic [DW-1:0] r_q  [NSTG];
  logic [NW-1:0] nq_q [NSTG];
  logic [DW-1:0] d_q  [NSTG];

  for (genvar g = 0; g < NSTG; g++) begin : g_stage
    localparam int STEPS = ((NW - g * BPS) < BPS) ? (NW - g * BPS) : BPS;
    logic [DW-1:0] r_in;
    logic [NW-1:0] nq_in;
    logic [DW-1:0] d_in;
    logic [DW-1:0] r_d;
    logic [NW-1:0] nq_d;
    logic [DW:0]   rs;

    if (g == 0) begin : g_first
      assign r_in  = '0;
      assign nq_in = num_i;
      assign d_in  = den_i;
    end else begin : g_next
      assign r_in  = r_q[g-1];
      assign nq_in = nq_q[g-1];
      assign d_in  = d_q[g-1];
    end

    always_comb begin
      r_d  = r_in;
      nq_d = nq_in;
      rs   = '0;
      for (int i = 0; i < STEPS; i++) begin
        rs   = {r_d, nq_d[NW-1]};
        nq_d = {nq_d[NW-2:0], 1'b0};
        if (rs >= {1'b0, d_in}) begin
          rs      = rs - {1'b0, d_in};
          nq_d[0] = 1'b1;
        end
        r_d = rs[DW-1:0];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[g]  <= r_d;
        nq_q[g] <= nq_d;
        d_q[g]  <= d_in;
      end
    end
  end

  assign quot_o = nq_q[NSTG-1];
  assign rem_o  = r_q[NSTG-1];

endmodule

>>> rtl/ctvg_step.sv
// One Horner step of the sine and cosine series, three register stages deep.
module ctvg_step import ctvg_pkg::*; #(
  parameter int unsigned SDEN = 6,
  parameter int unsigned CDEN = 2
) (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [30:0] x_i,
  input  logic [31:0] x2_i,
  input  logic [30:0] s_i,
  input  logic [30:0] c_i,
  output logic [30:0] x_o,
  output logic [31:0] x2_o,
  output logic [30:0] s_o,
  output logic [30:0] c_o
);

  logic [30:0] x_q  [STEP_LAT];
  logic [31:0] x2_q [STEP_LAT];
  logic [30:0] v_q  [2];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]  <= x_i;
      x2_q[0] <= x2_i;
      for (int i = 1; i < STEP_LAT; i++) begin
        x_q[i]  <= x_q[i-1];
        x2_q[i] <= x2_q[i-1];
      end
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_lane
    localparam int unsigned DEN   = (l == 0) ? SDEN : CDEN;
    localparam int unsigned DSAFE = (DEN == 0) ? 1 : DEN;
    localparam int unsigned SHIFT = 31 + $clog2(DSAFE + 1);
    localparam logic [63:0] MUL64 = (64'd1 << SHIFT) / 64'(DSAFE);
    localparam logic [31:0] MUL   = (MUL64 > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : MUL64[31:0];

    logic [30:0] v_in;
    logic [31:0] op_in;
    logic [62:0] prod;
    logic [31:0] p1_q;
    logic [31:0] p2_q;
    logic [63:0] e_q;
    logic [31:0] qe;
    logic [39:0] rem;
    logic [31:0] qf;
    logic [30:0] v_d;

    assign v_in  = (l == 0) ? s_i : c_i;
    assign op_in = (DEN == 0) ? {1'b0, x_i} : x2_i;
    assign prod  = 63'(op_in) * 63'(v_in);
    assign qe    = 32'(e_q >> SHIFT);
    assign rem   = 40'(p2_q) - 40'(qe) * 40'(DSAFE);
    assign qf    = (rem >= 40'(DSAFE)) ? qe + 32'd1 : qe;

    always_comb begin
      if (DEN == 0) begin
        v_d = p2_q[30:0];
      end else if (qf > 32'(Q30_ONE)) begin
        v_d = '0;
      end else begin
        v_d = 31'(32'(Q30_ONE) - qf);
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        p1_q   <= prod[61:30];
        p2_q   <= p1_q;
        e_q    <= 64'(p1_q) * 64'(MUL);
        v_q[l] <= v_d;
      end
    end
  end

  assign x_o  = x_q[STEP_LAT-1];
  assign x2_o = x2_q[STEP_LAT-1];
  assign s_o  = v_q[0];
  assign c_o  = v_q[1];

endmodule

>>> rtl/ctvg_angle.sv
// Sine and cosine of slice angle k*2pi/n as Q30 magnitudes with signs.
module ctvg_angle import ctvg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic [8:0]  k_i,
  input  logic [7:0]  n_i,
  output trig_t       trig_o
);

  localparam int Q_DLY = 1 + XDIV_LAT + 1 + HORNER_STEPS * STEP_LAT;

  logic [7:0]  p;
  logic [9:0]  four;
  logic [1:0]  q_d;
  logic [1:0]  q_q;
  logic [7:0]  r_q;
  logic [40:0] num_q;
  logic [40:0] x_full;
  logic [30:0] x_q;
  logic [31:0] x2_q;
  logic [61:0] xx;
  logic [1:0]  q_late;
  logic [30:0] xs  [HORNER_STEPS+1];
  logic [31:0] x2s [HORNER_STEPS+1];
  logic [30:0] ss  [HORNER_STEPS+1];
  logic [30:0] cs  [HORNER_STEPS+1];
  trig_t       trig_d;
  trig_t       trig_q;

  ctvg_div #(.NW(MOD_NW), .DW(8), .BPS(MOD_BPS)) u_mod (
    .clk_i  (clk_i),
    .en_i   (en_i),
    .num_i  (k_i),
    .den_i  (n_i),
    .quot_o (),
    .rem_o  (p)
  );

  always_comb begin
    four = {p, 2'b00};
    q_d  = '0;
    if (four >= {1'b0, n_i, 1'b0}) begin
      four   = four - {1'b0, n_i, 1'b0};
      q_d[1] = 1'b1;
    end
    if (four >= {2'b00, n_i}) begin
      four   = four - {2'b00, n_i};
      q_d[0] = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_q   <= q_d;
      r_q   <= four[7:0];
      num_q <= 41'(r_q) * 41'(PI_Q30) + 41'(n_i);
    end
  end

  ctvg_div #(.NW(XDIV_NW), .DW(9), .BPS(XDIV_BPS)) u_xdiv (
    .clk_i  (clk_i),
    .en_i   (en_i),
    .num_i  (num_q),
    .den_i  ({n_i, 1'b0}),
    .quot_o (x_full),
    .rem_o  ()
  );

  assign xx = 62'(x_full[30:0]) * 62'(x_full[30:0]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q  <= x_full[30:0];
      x2_q <= xx[61:30];
    end
  end

  assign xs[0]  = x_q;
  assign x2s[0] = x2_q;
  assign ss[0]  = Q30_ONE;
  assign cs[0]  = Q30_ONE;

  for (genvar i = 0; i < HORNER_STEPS; i++) begin : g_step
    ctvg_step #(.SDEN(SIN_DEN[i]), .CDEN(COS_DEN[i])) u_step (
      .clk_i (clk_i),
      .en_i  (en_i),
      .x_i   (xs[i]),
      .x2_i  (x2s[i]),
      .s_i   (ss[i]),
      .c_i   (cs[i]),
      .x_o   (xs[i+1]),
      .x2_o  (x2s[i+1]),
      .s_o   (ss[i+1]),
      .c_o   (cs[i+1])
    );
  end

  ctvg_dly #(.W(2), .N(Q_DLY)) u_qdly (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en_i),
    .d_i    (q_q),
    .q_o    (q_late)
  );

  always_comb begin
    case (q_late)
      2'd0:    trig_d = '{smag: ss[HORNER_STEPS], cmag: cs[HORNER_STEPS], sneg: 1'b0, cneg: 1'b0};
      2'd1:    trig_d = '{smag: cs[HORNER_STEPS], cmag: ss[HORNER_STEPS], sneg: 1'b0, cneg: 1'b1};
      2'd2:    trig_d = '{smag: ss[HORNER_STEPS], cmag: cs[HORNER_STEPS], sneg: 1'b1, cneg: 1'b1};
      default: trig_d = '{smag: cs[HORNER_STEPS], cmag: ss[HORNER_STEPS], sneg: 1'b1, cneg: 1'b0};
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) trig_q <= trig_d;
  end

  assign trig_o = trig_q;

endmodule

>>> rtl/ctvg_scale.sv
// Scales the trig values into the positions and normals of a tile's four corners.
module ctvg_scale import ctvg_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  trig_t      trig_i [2],
  input  logic [1:0] op_i,
  input  logic [7:0] ring_i,
  input  logic [7:0] stacks_i,
  output tile_t      tile_o
);

  typedef struct packed {
    logic [1:0]        op;
    logic [1:0]        hneg;
    logic [3:0]        sgn;
    logic [3:0][15:0]  sp;
    logic [3:0][15:0]  sn;
  } side_t;

  logic [22:0] capn_d [2][2][2];
  logic [22:0] capn_q [2][2][2];
  logic [22:0] capq   [2][2][2];
  logic [22:0] hn_d   [2];
  logic [22:0] hn_q   [2];
  logic [22:0] hq     [2];
  side_t       side_d;
  side_t       side_q;
  side_t       side_late;
  tile_t       tile_d;
  tile_t       tile_q;

  always_comb begin
    logic [7:0]  lvl;
    logic [8:0]  a2;
    logic [8:0]  mh;
    logic [39:0] prod;
    logic [30:0] m;
    logic [31:0] sum;
    side_d    = '0;
    side_d.op = op_i;
    for (int lv = 0; lv < 2; lv++) begin
      lvl = ring_i + 8'(lv);
      a2  = {lvl, 1'b0};
      side_d.hneg[lv] = a2 > {1'b0, stacks_i};
      mh  = side_d.hneg[lv] ? a2 - {1'b0, stacks_i} : {1'b0, stacks_i} - a2;
      hn_d[lv] = (23'(mh) << FRAC_BITS) + 23'(stacks_i);
      for (int a = 0; a < 2; a++) begin
        for (int cp = 0; cp < 2; cp++) begin
          m    = (cp == 0) ? trig_i[a].smag : trig_i[a].cmag;
          prod = 40'(m) * 40'(lvl) + (40'(stacks_i) << 16);
          capn_d[a][lv][cp] = prod[39:17];
        end
      end
    end
    for (int a = 0; a < 2; a++) begin
      side_d.sgn[2*a]     = trig_i[a].sneg;
      side_d.sgn[2*a + 1] = trig_i[a].cneg;
      for (int cp = 0; cp < 2; cp++) begin
        m   = (cp == 0) ? trig_i[a].smag : trig_i[a].cmag;
        sum = 32'(m) + 32'h0001_0000;
        side_d.sp[2*a + cp] = 16'(sum >> 17);
        sum = 32'(m) + 32'h0000_8000;
        side_d.sn[2*a + cp] = 16'(sum >> 16);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      capn_q <= capn_d;
      hn_q   <= hn_d;
      side_q <= side_d;
    end
  end

  for (genvar a = 0; a < 2; a++) begin : g_ang
    for (genvar lv = 0; lv < 2; lv++) begin : g_lvl
      for (genvar cp = 0; cp < 2; cp++) begin : g_cmp
        ctvg_div #(.NW(SDIV_NW), .DW(9), .BPS(SDIV_BPS)) u_cdiv (
          .clk_i  (clk_i),
          .en_i   (en_i),
          .num_i  (capn_q[a][lv][cp]),
          .den_i  ({1'b0, stacks_i}),
          .quot_o (capq[a][lv][cp]),
          .rem_o  ()
        );
      end
    end
  end

  for (genvar lv = 0; lv < 2; lv++) begin : g_hgt
    ctvg_div #(.NW(SDIV_NW), .DW(9), .BPS(SDIV_BPS)) u_hdiv (
      .clk_i  (clk_i),
      .en_i   (en_i),
      .num_i  (hn_q[lv]),
      .den_i  ({stacks_i, 1'b0}),
      .quot_o (hq[lv]),
      .rem_o  ()
    );
  end

  ctvg_dly #(.W($bits(side_t)), .N(SDIV_LAT)) u_sdly (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en_i),
    .d_i    (side_q),
    .q_o    (side_late)
  );

  always_comb begin
    logic a;
    logic lv;
    logic top;
    tile_d     = '0;
    tile_d.rev = side_late.op == OP_BOTTOM;
    top        = side_late.op == OP_TOP;
    for (int c = 0; c < 4; c++) begin
      a  = c[0];
      lv = c[1];
      if (side_late.op == OP_SIDE) begin
        tile_d.corner[c].px = apply_sign(side_late.sgn[2*a], side_late.sp[2*a]);
        tile_d.corner[c].pz = apply_sign(side_late.sgn[2*a + 1], side_late.sp[2*a + 1]);
        tile_d.corner[c].py = apply_sign(side_late.hneg[lv], hq[lv][15:0]);
        tile_d.corner[c].nx = apply_sign(side_late.sgn[2*a], side_late.sn[2*a]);
        tile_d.corner[c].nz = apply_sign(side_late.sgn[2*a + 1], side_late.sn[2*a + 1]);
      end else begin
        tile_d.corner[c].px = apply_sign(side_late.sgn[2*a], capq[a][lv][0][15:0]);
        tile_d.corner[c].pz = apply_sign(side_late.sgn[2*a + 1], capq[a][lv][1][15:0]);
        tile_d.corner[c].py = apply_sign(!top, CAP_HALF);
        tile_d.corner[c].ny = apply_sign(!top, CAP_ONE);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) tile_q <= tile_d;
  end

  assign tile_o = tile_q;

endmodule

>>> rtl/ctvg_emit.sv
// Holds one finished tile and sends its six vertices in winding order.
module ctvg_emit import ctvg_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         valid_i,
  input  tile_t        tile_i,
  output logic         adv_o,
  output logic         m_tvalid_o,
  input  logic         m_tready_i,
  output logic [103:0] m_tdata_o,
  output logic         m_tlast_o
);

  logic        full_q, full_d;
  logic [2:0]  cnt_q, cnt_d;
  tile_t       tile_q;
  logic        last;
  logic [1:0]  sel;
  corner_t     cur;

  assign last  = cnt_q == 3'(VERTS - 1);
  assign adv_o = !full_q || (m_tready_i && last);

  always_comb begin
    full_d = full_q;
    cnt_d  = cnt_q;
    if (adv_o) begin
      full_d = valid_i;
      cnt_d  = '0;
    end else if (m_tready_i) begin
      cnt_d = cnt_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      full_q <= full_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o && valid_i) tile_q <= tile_i;
  end

  assign sel       = tile_q.rev ? ORDER_REV[cnt_q] : ORDER_FWD[cnt_q];
  assign cur       = tile_q.corner[sel];
  assign m_tvalid_o = full_q;
  assign m_tlast_o = last;
  assign m_tdata_o = {5'b0, cnt_q, cur.nz, cur.ny, cur.nx, cur.pz, cur.py, cur.px};

endmodule

>>> rtl/cylinder_tile_vertex_generator_core.sv
// Top level of the cylinder tile vertex generator.
//
//   Port group   Dir  Carries
//   s_axis_*     in   one tile request per item
//   m_axis_*     out  one vertex per item, six per tile
//   cfg_*        in   stack_count and slice_count writes
//
// A tile passes through the pipeline into the output register, which sends one vertex
// per cycle while the output is ready; it takes a new tile when empty or as its last vertex leaves.
// The six-vertex output register sets the rate at which tiles are taken.
// Reset loads stack_count 1 and slice_count 3 and empties the pipeline.
// A stalled output freezes every stage; nothing is dropped or repeated.
module cylinder_tile_vertex_generator_core import ctvg_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [15:0]  s_axis_tdata_i,  // slice_index, ring_index
  input  logic [1:0]   s_axis_tuser_i,  // op
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [103:0] m_axis_tdata_o,  // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                                        // vertex_number, zero fill
  output logic         m_axis_tlast_o,
  input  logic         cfg_we_i,
  input  logic         cfg_index_i,
  input  logic [7:0]   cfg_wdata_i
);

  logic [7:0] stack_q, slice_q;
  logic [7:0] stacks, slices;
  logic       adv;
  logic [7:0] ring_in;
  logic       v0_q;
  logic [1:0] op_q;
  logic [7:0] ring_q;
  logic [8:0] k_q [2];
  trig_t      trig [2];
  logic [9:0] side_late;
  logic       v_late;
  tile_t      tile;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stack_q <= 8'd1;
      slice_q <= 8'd3;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_STACK_COUNT: stack_q <= cfg_wdata_i;
        CFG_SLICE_COUNT: slice_q <= cfg_wdata_i;
      endcase
    end
  end

  assign stacks  = (stack_q == 8'd0) ? 8'd1 : stack_q;
  assign slices  = (slice_q < 8'd3) ? 8'd3 : slice_q;
  assign ring_in = (s_axis_tdata_i[15:8] >= stacks) ? stacks - 8'd1 : s_axis_tdata_i[15:8];
  assign s_axis_tready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (adv) begin
      v0_q <= s_axis_tvalid_i && (s_axis_tuser_i != OP_UNUSED);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      op_q   <= s_axis_tuser_i;
      ring_q <= ring_in;
      k_q[0] <= {1'b0, s_axis_tdata_i[7:0]};
      k_q[1] <= {1'b0, s_axis_tdata_i[7:0]} + 9'd1;
    end
  end

  for (genvar a = 0; a < 2; a++) begin : g_ang
    ctvg_angle u_angle (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .k_i    (k_q[a]),
      .n_i    (slices),
      .trig_o (trig[a])
    );
  end

  ctvg_dly #(.W(10), .N(ANG_LAT)) u_side_dly (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .d_i    ({op_q, ring_q}),
    .q_o    (side_late)
  );

  ctvg_dly #(.W(1), .N(ANG_LAT + SCALE_LAT)) u_valid_dly (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .d_i    (v0_q),
    .q_o    (v_late)
  );

  ctvg_scale u_scale (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (adv),
    .trig_i   (trig),
    .op_i     (side_late[9:8]),
    .ring_i   (side_late[7:0]),
    .stacks_i (stacks),
    .tile_o   (tile)
  );

  ctvg_emit u_emit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (v_late),
    .tile_i     (tile),
    .adv_o      (adv),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .m_tdata_o  (m_axis_tdata_o),
    .m_tlast_o  (m_axis_tlast_o)
  );

endmodule

>>> rtl/ctvg_checker.sv
// Port-level checks of the vertex output stream, bound to the top level.
`include "cylinder_tile_vertex_generator_core_defines.svh"

module ctvg_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         m_tvalid_i,
  input logic         m_tready_i,
  input logic [103:0] m_tdata_i,
  input logic         m_tlast_i
);

  logic [2:0]  vnum;
  logic [15:0] nx, ny, nz;

  assign vnum = m_tdata_i[98:96];
  assign nx   = m_tdata_i[63:48];
  assign ny   = m_tdata_i[79:64];
  assign nz   = m_tdata_i[95:80];

  `CTVG_ASSERT_NOW(a_last_on_sixth, m_tvalid_i, m_tlast_i == (vnum == 3'd5))
  `CTVG_ASSERT_NEXT(a_vertex_order, m_tvalid_i && m_tready_i && !m_tlast_i, m_tvalid_i && (vnum == $past(vnum) + 3'd1))
  `CTVG_ASSERT_NEXT(a_stall_holds, m_tvalid_i && !m_tready_i, m_tvalid_i && $stable(m_tdata_i) && $stable(m_tlast_i))
  `CTVG_ASSERT_NOW(a_normal_axis, m_tvalid_i, (ny == 16'd0) || ((nx == 16'd0) && (nz == 16'd0)))

endmodule

bind cylinder_tile_vertex_generator_core ctvg_checker u_ctvg_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .m_tvalid_i (m_axis_tvalid_o),
  .m_tready_i (m_axis_tready_i),
  .m_tdata_i  (m_axis_tdata_o),
  .m_tlast_i  (m_axis_tlast_o)
);

>>> tb/sv/tb_cylinder_tile_vertex_generator_core.sv
// Self-checking testbench for the cylinder tile vertex generator, with its own vertex predictor.
`timescale 1ns / 1ps

module tb_cylinder_tile_vertex_generator_core;
  import ctvg_pkg::*;

  localparam int IDLE_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 100;

  typedef struct {
    logic [1:0] op;
    logic [7:0] slice;
    logic [7:0] ring;
  } tile_req_t;

  typedef struct {
    logic [15:0] px, py, pz, nx, ny, nz;
    logic [2:0]  num;
    logic        last;
  } vertex_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_valid = 1'b0;
  logic         s_ready;
  logic [15:0]  s_tdata = '0;
  logic [1:0]   s_tuser = OP_SIDE;
  logic         m_valid;
  logic         m_ready = 1'b0;
  logic [103:0] m_tdata;
  logic         m_tlast;
  logic         cfg_we = 1'b0;
  logic         cfg_index = CFG_STACK_COUNT;
  logic [7:0]   cfg_wdata = '0;

  tile_req_t tile_queue[$];
  vertex_t   vertex_queue[$];
  tile_req_t tile_on_bus;
  bit        tile_taken = 0;
  bit        calm = 0;
  int        fail_count = 0;
  int        idle_cycles = 0;
  int unsigned stacks_reg = 1;
  int unsigned slices_reg = 3;

  cylinder_tile_vertex_generator_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_wdata_i     (cfg_wdata)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic longint unsigned horner_step(longint unsigned acc, longint unsigned x2,
                                                  longint unsigned den);
    longint unsigned t;
    t = ((x2 * acc) >> 30) / den;
    return (t > 64'(Q30_ONE)) ? 64'd0 : 64'(Q30_ONE) - t;
  endfunction

  function automatic void angle_sin_cos(input int unsigned k, input int unsigned n,
                                        output longint unsigned smag,
                                        output longint unsigned cmag,
                                        output bit sneg, output bit cneg);
    longint unsigned sin_div[6] = '{156, 110, 72, 42, 20, 6};
    longint unsigned cos_div[7] = '{182, 132, 90, 56, 30, 12, 2};
    longint unsigned p, q, r, x, x2, s, c;
    p = k % n;
    q = (4 * p) / n;
    r = 4 * p - q * n;
    x = (r * 64'(PI_Q30) + n) / (2 * n);
    x2 = (x * x) >> 30;
    s = 64'(Q30_ONE);
    c = 64'(Q30_ONE);
    foreach (sin_div[i]) s = horner_step(s, x2, sin_div[i]);
    s = (x * s) >> 30;
    foreach (cos_div[i]) c = horner_step(c, x2, cos_div[i]);
    case (q & 3)
      0: begin smag = s; cmag = c; sneg = 0; cneg = 0; end
      1: begin smag = c; cmag = s; sneg = 0; cneg = 1; end
      2: begin smag = s; cmag = c; sneg = 1; cneg = 1; end
      default: begin smag = c; cmag = s; sneg = 1; cneg = 0; end
    endcase
  endfunction

  function automatic logic [15:0] round_scaled(longint unsigned mag, bit neg,
                                               longint unsigned mul, longint unsigned div);
    longint unsigned den, v;
    den = div << (30 - FRAC_BITS);
    v = (mag * mul + den / 2) / den;
    return neg ? 16'(-v) : 16'(v);
  endfunction

  function automatic void predict_tile(tile_req_t req);
    int unsigned fwd[6] = '{0, 2, 3, 0, 3, 1};
    int unsigned rev[6] = '{0, 3, 2, 0, 1, 3};
    int unsigned stacks, slices, ring, level, corner, a, m, h;
    longint unsigned smag[2], cmag[2];
    bit sneg[2], cneg[2];
    vertex_t v;
    if (req.op == OP_UNUSED) return;
    stacks = (stacks_reg < 1) ? 1 : stacks_reg;
    slices = (slices_reg < 3) ? 3 : slices_reg;
    ring = (req.ring >= stacks) ? stacks - 1 : req.ring;
    angle_sin_cos(req.slice, slices, smag[0], cmag[0], sneg[0], cneg[0]);
    angle_sin_cos(req.slice + 1, slices, smag[1], cmag[1], sneg[1], cneg[1]);
    for (int i = 0; i < 6; i++) begin
      corner = (req.op == OP_BOTTOM) ? rev[i] : fwd[i];
      level = ring + corner[1];
      v.nx = '0;
      v.ny = '0;
      v.nz = '0;
      if (req.op == OP_SIDE) begin
        a = 2 * level;
        m = (a > stacks) ? a - stacks : stacks - a;
        h = ((m << FRAC_BITS) + stacks) / (2 * stacks);
        v.px = round_scaled(smag[corner[0]], sneg[corner[0]], 1, 2);
        v.pz = round_scaled(cmag[corner[0]], cneg[corner[0]], 1, 2);
        v.py = (a > stacks) ? 16'(-h) : 16'(h);
        v.nx = round_scaled(smag[corner[0]], sneg[corner[0]], 1, 1);
        v.nz = round_scaled(cmag[corner[0]], cneg[corner[0]], 1, 1);
      end else begin
        v.px = round_scaled(smag[corner[0]], sneg[corner[0]], level, 2 * stacks);
        v.pz = round_scaled(cmag[corner[0]], cneg[corner[0]], level, 2 * stacks);
        v.py = (req.op == OP_TOP) ? CAP_HALF : 16'(-CAP_HALF);
        v.ny = (req.op == OP_TOP) ? CAP_ONE : 16'(-CAP_ONE);
      end
      v.num = 3'(i);
      v.last = (i == 5);
      vertex_queue = {vertex_queue, v};
    end
  endfunction

  function automatic void check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  always @(negedge clk_i) begin : drive
    logic      nv;
    tile_req_t nxt;
    nv = s_valid;
    nxt = tile_on_bus;
    if (tile_taken) begin
      nv = 0;
      tile_taken = 0;
    end
    if (!nv && rst_ni && tile_queue.size() > 0 && (calm || $urandom_range(0, 99) >= 7)) begin
      nxt = tile_queue.pop_front();
      nv = 1;
    end
    s_valid <= nv;
    tile_on_bus <= nxt;
    s_tdata <= {nxt.ring, nxt.slice};
    s_tuser <= nxt.op;
    m_ready <= calm || ($urandom_range(0, 99) >= 7);
  end

  always @(posedge clk_i) begin : observe
    vertex_t e;
    if (rst_ni) begin
      idle_cycles++;
      if (s_valid && s_ready) begin
        predict_tile(tile_on_bus);
        tile_taken = 1;
        idle_cycles = 0;
      end
      if (m_valid && m_ready) begin
        idle_cycles = 0;
        if (vertex_queue.size() == 0) begin
          $error("vertex with no tile outstanding");
          fail_count++;
        end else begin
          e = vertex_queue.pop_front();
          check_field("pos_x", e.px, m_tdata[15:0]);
          check_field("pos_y", e.py, m_tdata[31:16]);
          check_field("pos_z", e.pz, m_tdata[47:32]);
          check_field("norm_x", e.nx, m_tdata[63:48]);
          check_field("norm_y", e.ny, m_tdata[79:64]);
          check_field("norm_z", e.nz, m_tdata[95:80]);
          check_field("vertex_number", 16'(e.num), 16'(m_tdata[98:96]));
          check_field("last", 16'(e.last), 16'(m_tlast));
        end
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("** cylinder_tile_vertex_generator_core: FAILED **");
        $finish;
      end
    end
  end

  task automatic wait_drained();
    while (tile_queue.size() > 0 || s_valid) @(negedge clk_i);
    while (vertex_queue.size() > 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
  endtask

  task automatic write_reg(logic index, logic [7:0] value);
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    if (index == CFG_STACK_COUNT) stacks_reg = value;
    else slices_reg = value;
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic push_tile(logic [1:0] op, logic [7:0] slice, logic [7:0] ring);
    tile_req_t t;
    t.op = op;
    t.slice = slice;
    t.ring = ring;
    tile_queue = {tile_queue, t};
  endtask

  task automatic push_directed();
    push_tile(OP_SIDE, 8'd0, 8'd0);
    push_tile(OP_SIDE, 8'd1, 8'd254);
    push_tile(OP_SIDE, 8'd255, 8'd255);
    push_tile(OP_TOP, 8'd0, 8'd0);
    push_tile(OP_TOP, 8'd254, 8'd1);
    push_tile(OP_TOP, 8'd255, 8'd255);
    push_tile(OP_BOTTOM, 8'd0, 8'd0);
    push_tile(OP_BOTTOM, 8'd2, 8'd254);
    push_tile(OP_BOTTOM, 8'd255, 8'd255);
    push_tile(OP_UNUSED, 8'd3, 8'd0);
    push_tile(OP_SIDE, 8'hAA, 8'h55);
  endtask

  task automatic push_random(int count);
    logic [1:0] op;
    logic [7:0] ring;
    int         stacks;
    stacks = (stacks_reg < 1) ? 1 : stacks_reg;
    for (int i = 0; i < count; i++) begin
      op = ($urandom_range(0, 15) == 0) ? OP_UNUSED : 2'($urandom_range(0, 2));
      if ($urandom_range(0, 3) == 0) ring = 8'($urandom_range(0, 255));
      else ring = 8'($urandom_range(0, stacks - 1));
      push_tile(op, 8'($urandom_range(0, 255)), ring);
    end
  endtask

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    push_directed();
    wait_drained();
    write_reg(CFG_STACK_COUNT, 8'd255);
    write_reg(CFG_SLICE_COUNT, 8'd255);
    push_directed();
    wait_drained();
    write_reg(CFG_STACK_COUNT, 8'd0);
    write_reg(CFG_SLICE_COUNT, 8'd2);
    push_directed();
    wait_drained();
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin write_reg(CFG_STACK_COUNT, 8'd4); write_reg(CFG_SLICE_COUNT, 8'd8); end
        1: begin write_reg(CFG_STACK_COUNT, 8'd1); write_reg(CFG_SLICE_COUNT, 8'd3); end
        4: begin write_reg(CFG_STACK_COUNT, 8'd255); write_reg(CFG_SLICE_COUNT, 8'd255); end
        default: begin
          write_reg(CFG_STACK_COUNT, 8'($urandom_range(1, 40)));
          write_reg(CFG_SLICE_COUNT, 8'($urandom_range(3, 64)));
        end
      endcase
      calm = (ph == 2);
      push_random(45);
      wait_drained();
    end
    calm = 0;
    while (vertex_queue.size() > 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (fail_count == 0 && vertex_queue.size() == 0) begin
      $display("** cylinder_tile_vertex_generator_core: PASSED **");
    end else begin
      $display("** cylinder_tile_vertex_generator_core: FAILED **");
    end
    $finish;
  end

endmodule
